>>> src/lux_pkg.sv
`timescale 1ns / 1ps

package lux_pkg;

    localparam int CNT_W     = 16;
    localparam int RATIO_W   = 16;
    localparam int LUX_W     = 24;
    localparam int CFG_W     = 2;
    localparam int CFG_IDX_W = 2;
    localparam int COEF_W    = 19;
    localparam int PROD_W    = 35;
    localparam int LUT_W     = 16;
    localparam int SCALE_W   = 21;
    localparam int POW_MUL_W = 20;
    localparam int SUB_W     = 20;
    localparam int SUB_SHIFT = 16;
    localparam int POW_SHIFT = 13;
    localparam int LO_W      = 17;
    localparam int HI_W      = PROD_W - LO_W;
    localparam int PP_W      = PROD_W + SCALE_W;
    localparam int Q_FRAC    = 40;
    localparam int GAIN_SH   = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN  = 2'd0,
        CFG_INTEG = 2'd1
    } t_cfg_index;

    localparam logic [1:0] INTEG_13MS  = 2'd0;
    localparam logic [1:0] INTEG_101MS = 2'd1;
    localparam logic       GAIN_1X     = 1'b0;

    typedef enum logic [2:0] {
        BAND_POW  = 3'd0,
        BAND_LOW  = 3'd1,
        BAND_MID  = 3'd2,
        BAND_HIGH = 3'd3,
        BAND_TOP  = 3'd4
    } t_band;

    localparam logic [CNT_W-1:0]   COUNT_LIMIT = 16'hFFFF;
    localparam logic [RATIO_W-1:0] RATIO_MAX   = 16'hFFFF;
    localparam logic [LUX_W-1:0]   LUX_MAX     = 24'hFFFFFF;

    localparam logic [RATIO_W-1:0] BOUND_POW  = 16'd8192;
    localparam logic [RATIO_W-1:0] BOUND_LOW  = 16'd9994;
    localparam logic [RATIO_W-1:0] BOUND_MID  = 16'd13107;
    localparam logic [RATIO_W-1:0] BOUND_HIGH = 16'd21299;

    localparam logic [COEF_W-1:0] COEF_LOW_F  = 19'd375810;
    localparam logic [COEF_W-1:0] COEF_LOW_R  = 19'd520094;
    localparam logic [COEF_W-1:0] COEF_MID_F  = 19'd214748;
    localparam logic [COEF_W-1:0] COEF_MID_R  = 19'd256691;
    localparam logic [COEF_W-1:0] COEF_HIGH_F = 19'd24495;
    localparam logic [COEF_W-1:0] COEF_HIGH_R = 19'd18790;
    localparam logic [COEF_W-1:0] COEF_POW_K  = 19'd510027;
    localparam logic [POW_MUL_W-1:0] COEF_POW_MUL = 20'd1040187;

    localparam logic [SCALE_W-1:0] SCALE_13MS  = 21'd1923027;
    localparam logic [SCALE_W-1:0] SCALE_101MS = 21'd260846;
    localparam logic [SCALE_W-1:0] SCALE_402MS = 21'd65536;

endpackage

>>> src/two_channel_lux_calculation_top.sv
`timescale 1ns / 1ps

// channel   dir   handshake            payload
// input     in    i_valid / o_ready    i_full_count, i_ir_count
// output    out   o_valid / i_ready    o_lux, o_overflow
// config    in    i_cfg_we             i_cfg_index, i_cfg_data
//
// one transaction per cycle unless i_ready stalls the output, eleven register stages,
// with the result held in the output register
// the register stages hold the 16-step ratio divider (four stages of four steps)
// and the two-part 35x21 scale product
// synchronous reset clears stage valids and presets the config registers (x16 gain, 402 ms)
// each stage stalls only when it is full and the next one stalls

module two_channel_lux_calculation_top
    import lux_pkg::*;
#(
    parameter int POWER_TABLE_ENTRIES = 64,
    parameter int LUX_FRACTION_BITS   = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [CNT_W-1:0]     i_full_count,
    input  logic [CNT_W-1:0]     i_ir_count,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [LUX_W-1:0]     o_lux,
    output logic                 o_overflow
);

    localparam int DIV_STAGES = 4;
    localparam int DIV_STEPS  = RATIO_W / DIV_STAGES;
    localparam int DL         = DIV_STAGES - 1;
    localparam int ST_A       = DIV_STAGES;
    localparam int ST_B       = ST_A + 1;
    localparam int ST_C       = ST_A + 2;
    localparam int ST_D       = ST_A + 3;
    localparam int ST_E       = ST_A + 4;
    localparam int ST_F       = ST_A + 5;
    localparam int ST_G       = ST_A + 6;
    localparam int STAGES     = ST_G + 1;
    localparam int IDX_W      = $clog2(POWER_TABLE_ENTRIES);
    localparam int IDXP_W     = POW_SHIFT + IDX_W;
    localparam int SH_X1      = Q_FRAC - GAIN_SH - LUX_FRACTION_BITS;
    localparam int SH_X16     = Q_FRAC - LUX_FRACTION_BITS;
    localparam int SUBP_W     = POW_MUL_W + LUT_W;

    function automatic logic [LUT_W-1:0] power_entry(input int unsigned idx);
        logic [63:0] a;
        logic [63:0] target;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] mid;
        logic [63:0] p;
        logic [63:0] prod;
        a = (64'(idx) << 15) / POWER_TABLE_ENTRIES;
        target = (a * a) << 28;
        lo = 64'd0;
        hi = 64'd4096;
        for (int it = 0; it < 16; it++) begin
            mid = (lo + hi + 64'd1) >> 1;
            p = mid * mid * mid * mid * mid;
            if (lo < hi) begin
                if (p <= target) begin
                    lo = mid;
                end else begin
                    hi = mid - 64'd1;
                end
            end
        end
        prod = (a * lo) >> 12;
        return prod[LUT_W-1:0];
    endfunction

    // config registers
    logic       r_gain_select;
    logic [1:0] r_integration_select;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_select        <= 1'b1;
            r_integration_select <= 2'd2;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_GAIN:  r_gain_select        <= i_cfg_data[0];
                CFG_INTEG: r_integration_select <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // valid chain and per-stage enables
    logic [STAGES-1:0] r_vld;
    logic [STAGES-1:0] w_vld_src;
    logic [STAGES-1:0] w_en;

    assign w_vld_src = {r_vld[STAGES-2:0], i_valid};

    always_comb begin
        w_en[STAGES-1] = !r_vld[STAGES-1] || i_ready;
        for (int k = STAGES - 2; k >= 0; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < STAGES; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= w_vld_src[k];
                end
            end
        end
    end

    assign o_ready = w_en[0];
    assign o_valid = r_vld[ST_G];

    // ratio divider stages
    logic [CNT_W-1:0]   r_dv_full [DIV_STAGES];
    logic [CNT_W-1:0]   r_dv_ir   [DIV_STAGES];
    logic [CNT_W-1:0]   r_dv_rem  [DIV_STAGES];
    logic [RATIO_W-1:0] r_dv_q    [DIV_STAGES];
    logic               r_dv_ovf  [DIV_STAGES];
    logic               r_dv_sat  [DIV_STAGES];

    logic [CNT_W-1:0]   w_src_full [DIV_STAGES];
    logic [CNT_W-1:0]   w_src_ir   [DIV_STAGES];
    logic [CNT_W-1:0]   w_src_rem  [DIV_STAGES];
    logic [RATIO_W-1:0] w_src_q    [DIV_STAGES];
    logic               w_src_ovf  [DIV_STAGES];
    logic               w_src_sat  [DIV_STAGES];
    logic [CNT_W-1:0]   n_dv_rem   [DIV_STAGES];
    logic [RATIO_W-1:0] n_dv_q     [DIV_STAGES];

    always_comb begin
        w_src_full[0] = i_full_count;
        w_src_ir[0]   = i_ir_count;
        w_src_rem[0]  = {2'b00, i_ir_count[CNT_W-1:2]};
        w_src_q[0]    = '0;
        w_src_ovf[0]  = (i_full_count == COUNT_LIMIT) || (i_ir_count == COUNT_LIMIT);
        // quotient does not fit when ir >= 4 * full, zero full included
        w_src_sat[0]  = {2'b00, i_ir_count} >= {i_full_count, 2'b00};
        for (int s = 1; s < DIV_STAGES; s++) begin
            w_src_full[s] = r_dv_full[s-1];
            w_src_ir[s]   = r_dv_ir[s-1];
            w_src_rem[s]  = r_dv_rem[s-1];
            w_src_q[s]    = r_dv_q[s-1];
            w_src_ovf[s]  = r_dv_ovf[s-1];
            w_src_sat[s]  = r_dv_sat[s-1];
        end
    end

    always_comb begin
        logic [CNT_W-1:0]   rem;
        logic [RATIO_W-1:0] q;
        logic [CNT_W:0]     t;
        logic               nbit;
        for (int s = 0; s < DIV_STAGES; s++) begin
            rem = w_src_rem[s];
            q   = w_src_q[s];
            for (int j = 0; j < DIV_STEPS; j++) begin
                nbit = 1'b0;
                if (s == 0 && j == 0) begin
                    nbit = w_src_ir[s][1];
                end else if (s == 0 && j == 1) begin
                    nbit = w_src_ir[s][0];
                end
                t = {rem, nbit};
                if (t >= {1'b0, w_src_full[s]}) begin
                    t = t - {1'b0, w_src_full[s]};
                    q = {q[RATIO_W-2:0], 1'b1};
                end else begin
                    q = {q[RATIO_W-2:0], 1'b0};
                end
                rem = t[CNT_W-1:0];
            end
            n_dv_rem[s] = rem;
            n_dv_q[s]   = q;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int s = 0; s < DIV_STAGES; s++) begin
            if (w_en[s]) begin
                r_dv_full[s] <= w_src_full[s];
                r_dv_ir[s]   <= w_src_ir[s];
                r_dv_rem[s]  <= n_dv_rem[s];
                r_dv_q[s]    <= n_dv_q[s];
                r_dv_ovf[s]  <= w_src_ovf[s];
                r_dv_sat[s]  <= w_src_sat[s];
            end
        end
    end

    // stage a: band select, table index, coefficient products
    logic [RATIO_W-1:0] w_ratio;
    t_band              n_a_band;
    logic [COEF_W-1:0]  w_cf;
    logic [COEF_W-1:0]  w_cr;
    logic [IDXP_W-1:0]  w_idx_prod;

    t_band              r_a_band;
    logic [IDX_W-1:0]   r_a_idx;
    logic [PROD_W-1:0]  r_a_pf;
    logic [PROD_W-1:0]  r_a_pr;
    logic [CNT_W-1:0]   r_a_full;
    logic               r_a_ovf;

    always_comb begin
        w_ratio = r_dv_sat[DL] ? RATIO_MAX : r_dv_q[DL];
        w_cf = '0;
        w_cr = '0;
        if (w_ratio < BOUND_POW) begin
            n_a_band = BAND_POW;
        end else if (w_ratio < BOUND_LOW) begin
            n_a_band = BAND_LOW;
            w_cf = COEF_LOW_F;
            w_cr = COEF_LOW_R;
        end else if (w_ratio < BOUND_MID) begin
            n_a_band = BAND_MID;
            w_cf = COEF_MID_F;
            w_cr = COEF_MID_R;
        end else if (w_ratio < BOUND_HIGH) begin
            n_a_band = BAND_HIGH;
            w_cf = COEF_HIGH_F;
            w_cr = COEF_HIGH_R;
        end else begin
            n_a_band = BAND_TOP;
        end
        w_idx_prod = IDXP_W'(w_ratio[POW_SHIFT-1:0]) * IDXP_W'(POWER_TABLE_ENTRIES);
    end

    always_ff @(posedge i_clk) begin
        if (w_en[ST_A]) begin
            r_a_band <= n_a_band;
            r_a_idx  <= w_idx_prod[POW_SHIFT +: IDX_W];
            r_a_pf   <= PROD_W'(r_dv_full[DL]) * PROD_W'(w_cf);
            r_a_pr   <= PROD_W'(r_dv_ir[DL]) * PROD_W'(w_cr);
            r_a_full <= r_dv_full[DL];
            r_a_ovf  <= r_dv_ovf[DL];
        end
    end

    // stage b: table read, band difference
    logic [LUT_W-1:0] w_lut [POWER_TABLE_ENTRIES];

    for (genvar g = 0; g < POWER_TABLE_ENTRIES; g++) begin : g_lut
        assign w_lut[g] = power_entry(g);
    end

    t_band             r_b_band;
    logic [LUT_W-1:0]  r_b_p;
    logic [PROD_W-1:0] r_b_d;
    logic [CNT_W-1:0]  r_b_full;
    logic              r_b_ovf;

    always_ff @(posedge i_clk) begin
        if (w_en[ST_B]) begin
            r_b_band <= r_a_band;
            r_b_p    <= w_lut[r_a_idx];
            r_b_d    <= (r_a_pf > r_a_pr) ? (r_a_pf - r_a_pr) : '0;
            r_b_full <= r_a_full;
            r_b_ovf  <= r_a_ovf;
        end
    end

    // stage c: power term product
    logic [SUBP_W-1:0] w_sub_prod;

    t_band             r_c_band;
    logic [SUB_W-1:0]  r_c_sub;
    logic [PROD_W-1:0] r_c_d;
    logic [CNT_W-1:0]  r_c_full;
    logic              r_c_ovf;

    assign w_sub_prod = SUBP_W'(r_b_p) * SUBP_W'(COEF_POW_MUL);

    always_ff @(posedge i_clk) begin
        if (w_en[ST_C]) begin
            r_c_band <= r_b_band;
            r_c_sub  <= w_sub_prod[SUB_SHIFT +: SUB_W];
            r_c_d    <= r_b_d;
            r_c_full <= r_b_full;
            r_c_ovf  <= r_b_ovf;
        end
    end

    // stage d: power band coefficient
    logic [SUB_W-1:0]  w_k_diff;

    t_band             r_d_band;
    logic [COEF_W-1:0] r_d_k;
    logic [PROD_W-1:0] r_d_d;
    logic [CNT_W-1:0]  r_d_full;
    logic              r_d_ovf;

    assign w_k_diff = SUB_W'(COEF_POW_K) - r_c_sub;

    always_ff @(posedge i_clk) begin
        if (w_en[ST_D]) begin
            r_d_band <= r_c_band;
            r_d_k    <= (r_c_sub >= SUB_W'(COEF_POW_K)) ? '0 : w_k_diff[COEF_W-1:0];
            r_d_d    <= r_c_d;
            r_d_full <= r_c_full;
            r_d_ovf  <= r_c_ovf;
        end
    end

    // stage e: band result before scaling
    logic [PROD_W-1:0] n_e_d;
    logic [PROD_W-1:0] r_e_d;
    logic              r_e_ovf;

    always_comb begin
        unique case (r_d_band)
            BAND_POW: n_e_d = PROD_W'(r_d_full) * PROD_W'(r_d_k);
            BAND_TOP: n_e_d = '0;
            default:  n_e_d = r_d_d;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_en[ST_E]) begin
            r_e_d   <= n_e_d;
            r_e_ovf <= r_d_ovf;
        end
    end

    // stage f: integration scale, split product
    logic [SCALE_W-1:0]      w_scale;
    logic [HI_W+SCALE_W-1:0] r_f_pphi;
    logic [LO_W+SCALE_W-1:0] r_f_pplo;
    logic                    r_f_ovf;

    always_comb begin
        unique case (r_integration_select)
            INTEG_13MS:  w_scale = SCALE_13MS;
            INTEG_101MS: w_scale = SCALE_101MS;
            default:     w_scale = SCALE_402MS;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_en[ST_F]) begin
            r_f_pphi <= (HI_W + SCALE_W)'(r_e_d[PROD_W-1:LO_W]) * (HI_W + SCALE_W)'(w_scale);
            r_f_pplo <= (LO_W + SCALE_W)'(r_e_d[LO_W-1:0]) * (LO_W + SCALE_W)'(w_scale);
            r_f_ovf  <= r_e_ovf;
        end
    end

    // stage g: sum, gain shift, saturate
    logic [PP_W-1:0]  w_full_prod;
    logic [PP_W-1:0]  w_shifted;
    logic [LUX_W-1:0] n_o_lux;
    logic [LUX_W-1:0] r_o_lux;
    logic             r_o_ovf;

    always_comb begin
        w_full_prod = (PP_W'(r_f_pphi) << LO_W) + PP_W'(r_f_pplo);
        if (r_gain_select == GAIN_1X) begin
            w_shifted = w_full_prod >> SH_X1;
        end else begin
            w_shifted = w_full_prod >> SH_X16;
        end
        if (r_f_ovf || (|w_shifted[PP_W-1:LUX_W])) begin
            n_o_lux = LUX_MAX;
        end else begin
            n_o_lux = w_shifted[LUX_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[ST_G]) begin
            r_o_lux <= n_o_lux;
            r_o_ovf <= r_f_ovf;
        end
    end

    assign o_lux      = r_o_lux;
    assign o_overflow = r_o_ovf;

endmodule

>>> src/lux_chk.sv
`timescale 1ns / 1ps

module lux_chk
    import lux_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             o_ready,
    input logic             o_valid,
    input logic             i_ready,
    input logic [LUX_W-1:0] o_lux,
    input logic             o_overflow
);

    // overflow transactions always carry full-scale lux
    a_ovf_lux : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_overflow |-> o_lux == LUX_MAX)
        else $error("overflow without saturated lux");

    // an empty output stage means nothing upstream can stall
    a_ready_when_empty : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("input stalled with empty output");

    // reset empties the pipeline
    a_reset_empty : assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    // stalled output transaction holds
    a_out_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_lux) && $stable(o_overflow))
        else $error("stalled output changed");

endmodule

bind two_channel_lux_calculation_top lux_chk u_lux_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_ready    (o_ready),
    .o_valid    (o_valid),
    .i_ready    (i_ready),
    .o_lux      (o_lux),
    .o_overflow (o_overflow)
);
